>>> rtl/core/text_console_writer_top_assert.svh
// Assertion macros used by the text console writer RTL.
`ifndef TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH

// Checks cons in the same cycle as ante.
`define TCW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks cons in the cycle after ante.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/tcw_pkg.sv
// Shared constants, types and tables of the text console writer.
package tcw_pkg;

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 8;
  localparam int CELLS    = ROWS * COLUMNS;

  localparam int KIND_W = 2;
  localparam int CH_W   = 8;
  localparam int ATTR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int IDX_W  = 11;
  localparam int CELL_W = CH_W + ATTR_W;
  localparam int TAB_W  = COL_W + 1;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  typedef logic [CH_W-1:0]   byte_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [TAB_W-1:0]  tab_t;
  typedef tab_t [COLUMNS-1:0] tab_tbl_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PRINT  = 2'd0,
    KIND_READ   = 2'd1,
    KIND_HEADER = 2'd2,
    KIND_SPIN   = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RMW,
    ST_MOVE,
    ST_READ,
    ST_SCROLL_CP,
    ST_SCROLL_BL,
    ST_DONE
  } state_t;

  localparam byte_t CH_END   = 8'h00;
  localparam byte_t CH_TAB   = 8'h09;
  localparam byte_t CH_NL    = 8'h0A;
  localparam byte_t CH_SPACE = 8'h20;

  localparam logic [1:0] REG_NORMAL = 2'd0;
  localparam logic [1:0] REG_CURSOR = 2'd1;
  localparam logic [1:0] REG_HEADER = 2'd2;

  localparam byte_t NORMAL_ATTR_RST = 8'd7;
  localparam byte_t CURSOR_ATTR_RST = 8'd112;
  localparam byte_t HEADER_ATTR_RST = 8'd31;

  localparam cell_t BLANK_RST = {NORMAL_ATTR_RST, CH_SPACE};

  // Spinner symbols in order: slash, dash, backslash, bar.
  localparam byte_t [3:0] SPIN_GLYPHS = {8'h7C, 8'h5C, 8'h2D, 8'h2F};

  localparam idx_t SPIN_ADDR   = idx_t'(COLUMNS - 1);
  localparam idx_t ROW1_BASE   = idx_t'(COLUMNS);
  localparam idx_t ROW2_BASE   = idx_t'(2 * COLUMNS);
  localparam idx_t BOTTOM_BASE = idx_t'((ROWS - 1) * COLUMNS);
  localparam idx_t SCROLL_N    = idx_t'((ROWS - 2) * COLUMNS);
  localparam idx_t CELLS_IDX   = idx_t'(CELLS);

  function automatic tab_tbl_t build_tab_tbl();
    tab_tbl_t t;
    for (int i = 0; i < COLUMNS; i++) begin
      t[i] = tab_t'(((i + TAB_STOP) / TAB_STOP) * TAB_STOP);
    end
    return t;
  endfunction

  // Next tab stop for each column.
  localparam tab_tbl_t TAB_NEXT = build_tab_tbl();

  typedef struct packed {
    byte_t normal_attr;
    byte_t cursor_attr;
    byte_t header_attr;
  } cfg_t;

  typedef struct packed {
    logic  we;
    idx_t  waddr;
    cell_t wdata;
    logic  re;
    idx_t  raddr;
  } mem_req_t;

endpackage

>>> rtl/core/tcw_if.sv
// Item channel interfaces of the text console writer.
interface tcw_in_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CH_W-1:0]   char_code;
  logic [IDX_W-1:0]  cell_index;

  modport source (output valid, kind, char_code, cell_index, input ready);
  modport sink   (input valid, kind, char_code, cell_index, output ready);
endinterface

interface tcw_out_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic [CH_W-1:0]   cell_char;
  logic [ATTR_W-1:0] cell_attr;

  modport source (output valid, cursor_col, cursor_row, cell_char, cell_attr, input ready);
  modport sink   (input valid, cursor_col, cursor_row, cell_char, cell_attr, output ready);
endinterface

>>> rtl/core/text_console_writer_top.sv
// Text console writer: screen store, cursor sequencer and APB attribute registers.
// Item path: printable byte: execute, move. Tab or newline: execute, cursor-cell rewrite when
// no message is open, move. Message end or spinner tick: execute, rewrite. Read: execute, read.
// Header write: execute. Each then waits in done to load its result before idle, the only
// state that accepts items. A scroll copies rows 2 to ROWS-1 up one row, one cell per cycle,
// then blanks the bottom row. Reset: synchronous active low; a clearing pass then fills the
// store with blanks, during which no item is accepted but register writes are taken.
module text_console_writer_top import tcw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  tcw_in_if.sink            in_ch,
  tcw_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_t     cfg;
  mem_req_t mem_req;
  cell_t    rd_data;

  tcw_cfg_regs u_cfg_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  tcw_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg     (cfg),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  tcw_screen_ram u_screen_ram (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

endmodule

>>> rtl/core/tcw_screen_ram.sv
// Screen store: one write port and one registered read port.
module tcw_screen_ram import tcw_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output cell_t    rd_data
);

  cell_t mem [CELLS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

>>> rtl/core/tcw_cfg_regs.sv
// APB attribute registers of the text console writer.
module tcw_cfg_regs import tcw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_sel;
  byte_t      rd_byte;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_sel    = cfg_paddr[3:2];
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.normal_attr <= NORMAL_ATTR_RST;
      cfg_r.cursor_attr <= CURSOR_ATTR_RST;
      cfg_r.header_attr <= HEADER_ATTR_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_NORMAL: cfg_r.normal_attr <= cfg_pwdata[CH_W-1:0];
        REG_CURSOR: cfg_r.cursor_attr <= cfg_pwdata[CH_W-1:0];
        REG_HEADER: cfg_r.header_attr <= cfg_pwdata[CH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_NORMAL: rd_byte = cfg_r.normal_attr;
      REG_CURSOR: rd_byte = cfg_r.cursor_attr;
      REG_HEADER: rd_byte = cfg_r.header_attr;
      default:    rd_byte = '0;
    endcase
  end

  assign cfg_prdata = {{(CFG_DW - CH_W){1'b0}}, rd_byte};

endmodule

>>> rtl/core/tcw_ctrl.sv
// Cursor sequencer: decodes items and runs read-modify-write, scroll and clear sweeps.
`include "text_console_writer_top_assert.svh"

module tcw_ctrl import tcw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  tcw_in_if.sink   in_ch,
  tcw_out_if.source out_ch,
  input  cfg_t     cfg,
  output mem_req_t mem_req,
  input  cell_t    rd_data
);

  state_t state_r, state_nxt;
  idx_t   cnt_r, cnt_nxt;
  col_t   cur_col_r, cur_col_nxt;
  row_t   cur_row_r, cur_row_nxt;
  logic   msg_open_r, msg_open_nxt;
  logic [1:0] spin_r, spin_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_load;

  kind_t  kind_r;
  byte_t  ch_r;
  idx_t   idx_r;
  byte_t  rd_char_r, rd_char_nxt;
  byte_t  rd_attr_r, rd_attr_nxt;
  col_t   out_col_r;
  row_t   out_row_r;
  byte_t  out_char_r;
  byte_t  out_attr_r;

  idx_t   cur_addr;
  tab_t   mv_adv;
  col_t   mv_col;
  row_t   mv_row;
  logic   mv_scroll;
  logic   is_ctrl_ch;
  logic   need_rmw;

  assign cur_addr   = idx_t'(cur_row_r) * ROW1_BASE + idx_t'(cur_col_r);
  assign is_ctrl_ch = (ch_r == CH_TAB) || (ch_r == CH_NL);
  // The cursor cell's attribute is rewritten in place when no character replaces it.
  assign need_rmw   = (ch_r == CH_END) || (!msg_open_r && is_ctrl_ch);

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.cursor_col = out_col_r;
  assign out_ch.cursor_row = out_row_r;
  assign out_ch.cell_char  = out_char_r;
  assign out_ch.cell_attr  = out_attr_r;

  // Cursor advance for a print item.
  always_comb begin
    mv_adv    = (ch_r == CH_TAB) ? TAB_NEXT[cur_col_r] : ({1'b0, cur_col_r} + tab_t'(1));
    mv_col    = col_t'(mv_adv);
    mv_row    = cur_row_r;
    mv_scroll = 1'b0;
    if ((ch_r == CH_NL) || (mv_adv >= tab_t'(COLUMNS))) begin
      mv_col = '0;
      if (cur_row_r == row_t'(ROWS - 1)) begin
        mv_scroll = 1'b1;
      end else begin
        mv_row = cur_row_r + row_t'(1);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (cnt_r == idx_t'(CELLS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_ch.valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        case (kind_r)
          KIND_PRINT:  state_nxt = need_rmw ? ST_RMW : ST_MOVE;
          KIND_READ:   state_nxt = (idx_r < CELLS_IDX) ? ST_READ : ST_DONE;
          KIND_HEADER: state_nxt = ST_DONE;
          KIND_SPIN:   state_nxt = ST_RMW;
          default:     state_nxt = ST_DONE;
        endcase
      end
      ST_RMW: begin
        state_nxt = ((kind_r == KIND_SPIN) || (ch_r == CH_END)) ? ST_DONE : ST_MOVE;
      end
      ST_MOVE: begin
        state_nxt = mv_scroll ? ST_SCROLL_CP : ST_DONE;
      end
      ST_READ: begin
        state_nxt = ST_DONE;
      end
      ST_SCROLL_CP: begin
        if (cnt_r == SCROLL_N) state_nxt = ST_SCROLL_BL;
      end
      ST_SCROLL_BL: begin
        if (cnt_r == idx_t'(COLUMNS - 1)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_req       = '0;
    cnt_nxt       = cnt_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    msg_open_nxt  = msg_open_r;
    spin_nxt      = spin_r;
    rd_char_nxt   = rd_char_r;
    rd_attr_nxt   = rd_attr_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_load      = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cnt_r;
        mem_req.wdata = BLANK_RST;
        cnt_nxt       = cnt_r + idx_t'(1);
      end
      ST_EXEC: begin
        rd_char_nxt = '0;
        rd_attr_nxt = '0;
        case (kind_r)
          KIND_PRINT: begin
            msg_open_nxt = (ch_r != CH_END);
            if (need_rmw) begin
              mem_req.re    = 1'b1;
              mem_req.raddr = cur_addr;
            end else if (!is_ctrl_ch) begin
              mem_req.we    = 1'b1;
              mem_req.waddr = cur_addr;
              mem_req.wdata = {cfg.normal_attr, ch_r};
            end
          end
          KIND_READ: begin
            if (idx_r < CELLS_IDX) begin
              mem_req.re    = 1'b1;
              mem_req.raddr = idx_r;
            end
          end
          KIND_HEADER: begin
            if ((ch_r != CH_END) && (idx_r < CELLS_IDX)) begin
              mem_req.we    = 1'b1;
              mem_req.waddr = idx_r;
              mem_req.wdata = {cfg.header_attr, ch_r};
            end
          end
          KIND_SPIN: begin
            mem_req.re    = 1'b1;
            mem_req.raddr = SPIN_ADDR;
          end
          default: ;
        endcase
      end
      ST_RMW: begin
        mem_req.we = 1'b1;
        if (kind_r == KIND_SPIN) begin
          mem_req.waddr = SPIN_ADDR;
          mem_req.wdata = {rd_data[CELL_W-1:CH_W], SPIN_GLYPHS[spin_r]};
          spin_nxt      = spin_r + 2'd1;
        end else begin
          mem_req.waddr = cur_addr;
          mem_req.wdata = {(ch_r == CH_END) ? cfg.cursor_attr : cfg.normal_attr,
                           rd_data[CH_W-1:0]};
        end
      end
      ST_MOVE: begin
        cur_col_nxt = mv_col;
        cur_row_nxt = mv_row;
        cnt_nxt     = '0;
      end
      ST_READ: begin
        rd_char_nxt = rd_data[CH_W-1:0];
        rd_attr_nxt = rd_data[CELL_W-1:CH_W];
      end
      ST_SCROLL_CP: begin
        // Read a cell one row down while writing the previous read one row up.
        mem_req.re    = (cnt_r < SCROLL_N);
        mem_req.raddr = ROW2_BASE + cnt_r;
        mem_req.we    = (cnt_r != '0);
        mem_req.waddr = ROW1_BASE + cnt_r - idx_t'(1);
        mem_req.wdata = rd_data;
        cnt_nxt       = (cnt_r == SCROLL_N) ? '0 : (cnt_r + idx_t'(1));
      end
      ST_SCROLL_BL: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = BOTTOM_BASE + cnt_r;
        mem_req.wdata = {cfg.normal_attr, CH_SPACE};
        cnt_nxt       = cnt_r + idx_t'(1);
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      cur_col_r   <= '0;
      cur_row_r   <= row_t'(ROWS - 1);
      msg_open_r  <= 1'b0;
      spin_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      msg_open_r  <= msg_open_nxt;
      spin_r      <= spin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      kind_r <= kind_t'(in_ch.kind);
      ch_r   <= in_ch.char_code;
      idx_r  <= in_ch.cell_index;
    end
    rd_char_r <= rd_char_nxt;
    rd_attr_r <= rd_attr_nxt;
    if (out_load) begin
      out_col_r  <= cur_col_r;
      out_row_r  <= cur_row_r;
      out_char_r <= rd_char_r;
      out_attr_r <= rd_attr_r;
    end
  end

  `TCW_ASSERT_NEXT(a_accept_starts_exec, in_ch.valid && in_ch.ready, state_r == ST_EXEC, "accepted item did not start execution")
  `TCW_ASSERT_SAME(a_write_in_range, mem_req.we, mem_req.waddr < CELLS_IDX, "screen write outside the store")
  `TCW_ASSERT_SAME(a_scroll_keeps_status, (state_r == ST_SCROLL_CP) && mem_req.we, mem_req.waddr >= ROW1_BASE, "scroll wrote into the status row")
  `TCW_ASSERT_SAME(a_result_from_done, $rose(out_valid_r), $past(state_r) == ST_DONE, "result raised outside the done state")

endmodule
